### design/mkd_pkg.sv
`default_nettype none

package mkd_pkg;

  localparam int MaxElements = 6;
  localparam int CntW        = $clog2(MaxElements + 1);
  localparam int TickW       = 16;
  localparam int CharW       = 7;
  localparam int TableSize   = 53;
  localparam int CodeW       = 6;
  localparam int LenW        = 3;
  localparam int CmpW        = (MaxElements > CodeW) ? MaxElements : CodeW;
  localparam int CntCmpW     = (CntW > LenW) ? CntW : LenW;

  localparam int PaddrW      = 3;
  localparam int PdataW      = 32;
  localparam logic [0:0] RegDotMax = 1'b0;
  localparam logic [TickW-1:0] DotMaxReset = TickW'(6);

  typedef struct packed {
    logic             hit;
    logic [CharW-1:0] ascii;
  } mkd_hit_t;

  // Bit i of a code is element i of the sequence; 1 is a dash.
  localparam logic [CodeW-1:0] MkCode [TableSize] = '{
    6'b000010, 6'b000001, 6'b000101, 6'b000001, 6'b000000,
    6'b000100, 6'b000011, 6'b000000, 6'b000000, 6'b001110,
    6'b000101, 6'b000010, 6'b000011, 6'b000001, 6'b000111,
    6'b000110, 6'b001011, 6'b000010, 6'b000000, 6'b000001,
    6'b000100, 6'b001000, 6'b000110, 6'b001001, 6'b001101,
    6'b000011,
    6'b011110, 6'b011100, 6'b011000, 6'b010000, 6'b000000,
    6'b000001, 6'b000011, 6'b000111, 6'b001111, 6'b011111,
    6'b101010, 6'b110011, 6'b011110, 6'b010010, 6'b101100,
    6'b000111, 6'b010101, 6'b001100, 6'b110101, 6'b100001,
    6'b001010, 6'b001001, 6'b001101, 6'b101101, 6'b010001,
    6'b010110, 6'b010010
  };

  localparam logic [LenW-1:0] MkLen [TableSize] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1,
    3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3,
    3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4,
    3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
    3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
    3'd5, 3'd5, 3'd5, 3'd6, 3'd5,
    3'd6, 3'd5
  };

  localparam logic [CharW-1:0] MkChar [TableSize] = '{
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45,
    7'h46, 7'h47, 7'h48, 7'h49, 7'h4A,
    7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F,
    7'h50, 7'h51, 7'h52, 7'h53, 7'h54,
    7'h55, 7'h56, 7'h57, 7'h58, 7'h59,
    7'h5A,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35,
    7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h2E, 7'h2C, 7'h27, 7'h22, 7'h5F,
    7'h3A, 7'h3B, 7'h3F, 7'h21, 7'h2D,
    7'h2B, 7'h2F, 7'h28, 7'h29, 7'h3D,
    7'h40, 7'h20
  };

endpackage

`default_nettype wire

### design/mkd_lookup.sv
`default_nettype none

module mkd_lookup (
  input  wire logic [mkd_pkg::MaxElements-1:0] elem_bits_i,
  input  wire logic [mkd_pkg::CntW-1:0]        elem_cnt_i,
  output mkd_pkg::mkd_hit_t                    result_o
);

  logic [mkd_pkg::CmpW-1:0]    bits_ext;
  logic [mkd_pkg::CntCmpW-1:0] cnt_ext;

  assign bits_ext = mkd_pkg::CmpW'(elem_bits_i);
  assign cnt_ext  = mkd_pkg::CntCmpW'(elem_cnt_i);

  // Bits above the element count are always zero, so a full-width compare suffices.
  always_comb begin
    result_o.hit   = 1'b0;
    result_o.ascii = '0;
    for (int k = mkd_pkg::TableSize - 1; k >= 0; k--) begin
      if ((cnt_ext == mkd_pkg::CntCmpW'(mkd_pkg::MkLen[k])) &&
          (bits_ext == mkd_pkg::CmpW'(mkd_pkg::MkCode[k]))) begin
        result_o.hit   = 1'b1;
        result_o.ascii = mkd_pkg::MkChar[k];
      end
    end
  end

endmodule

`default_nettype wire

### design/morse_key_decoder.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o  kind_i, press_ticks_i
// output    out        out_valid_o/out_stall_i  ascii_char_o
// config    in         APB write/read           paddr, pwdata, prdata
//
// One transaction is taken per cycle while in_stall_o is low.
// The sequence state updates in the accept cycle, and the table match is one
// combinational pass from the state registers to the output or skid register.
// Reset clears the sequence and sets the dot threshold to 6.
// A skid register holds one character while the output is stalled; input then stalls.

module morse_key_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mkd_pkg::PaddrW-1:0]    paddr,
  input  wire logic [mkd_pkg::PdataW-1:0]    pwdata,
  output logic [mkd_pkg::PdataW-1:0]         prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic [mkd_pkg::TickW-1:0]     press_ticks_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mkd_pkg::CharW-1:0]          ascii_char_o
);

  logic [mkd_pkg::TickW-1:0]       dot_max_q;
  logic [mkd_pkg::MaxElements-1:0] elem_bits_q, elem_bits_d;
  logic [mkd_pkg::CntW-1:0]        elem_cnt_q, elem_cnt_d;
  logic                            too_long_q, too_long_d;
  logic                            out_valid_q, skid_valid_q;
  logic [mkd_pkg::CharW-1:0]       out_char_q, skid_char_q;
  logic                            accept, is_dash, full, produce, out_take, reg_sel;
  mkd_pkg::mkd_hit_t               match;

  mkd_lookup u_lookup (
    .elem_bits_i (elem_bits_q),
    .elem_cnt_i  (elem_cnt_q),
    .result_o    (match)
  );

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == mkd_pkg::RegDotMax);
  assign prdata  = reg_sel ? mkd_pkg::PdataW'(dot_max_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_max_q <= mkd_pkg::DotMaxReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      dot_max_q <= pwdata[mkd_pkg::TickW-1:0];
    end
  end

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_dash    = press_ticks_i > dot_max_q;
  assign full       = elem_cnt_q == mkd_pkg::CntW'(mkd_pkg::MaxElements);
  assign produce    = accept && kind_i && !too_long_q && match.hit;

  always_comb begin
    elem_bits_d = elem_bits_q;
    elem_cnt_d  = elem_cnt_q;
    too_long_d  = too_long_q;
    if (accept) begin
      if (kind_i) begin
        elem_bits_d = '0;
        elem_cnt_d  = '0;
        too_long_d  = 1'b0;
      end else if (full) begin
        too_long_d = 1'b1;
      end else begin
        elem_bits_d = elem_bits_q | (mkd_pkg::MaxElements'(is_dash) << elem_cnt_q);
        elem_cnt_d  = elem_cnt_q + mkd_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_bits_q <= '0;
      elem_cnt_q  <= '0;
      too_long_q  <= 1'b0;
    end else begin
      elem_bits_q <= elem_bits_d;
      elem_cnt_q  <= elem_cnt_d;
      too_long_q  <= too_long_d;
    end
  end

  assign out_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (produce) begin
      if (out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_char_q <= skid_char_q;
      end
    end else if (produce) begin
      if (out_take) begin
        out_char_q <= match.ascii;
      end else begin
        skid_char_q <= match.ascii;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = out_char_q;

endmodule

`default_nettype wire
